// ===== hdl/smpc_pkg.sv =====
package smpc_pkg;

	// Default control tick rate and the width that holds any allowed rate.
	localparam int SAMPLE_RATE_HZ_DEF = 1000;
	localparam int SR_W = 17;

	// Gain registers are unsigned Q15.16 with 31 bits.
	localparam int GAIN_W = 31;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE,
		REG_GAIN_J,
		REG_GAIN_K,
		REG_SURF_GAIN,
		REG_INT_GAIN,
		REG_EPS,
		REG_SAT_LIMIT,
		REG_DRIVE_MAX
	} reg_idx_t;

	// Input and result payloads.
	typedef struct packed {
		logic signed [31:0] target_pos;
		logic signed [31:0] measured_pos;
		logic signed [31:0] measured_vel;
		logic [30:0] deadband_width;
	} in_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic signed [31:0] surface;
		logic in_deadband;
		logic clamped;
	} out_t;

	// Operand pairs of the shared gain multiplier.
	typedef enum logic [2:0] {
		MS_EC,
		MS_IC,
		MS_TH,
		MS_EVC,
		MS_EC2,
		MS_SK,
		MS_SSE,
		MS_UJ
	} mul_sel_t;

	// Accumulator operations.
	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_EV,
		ACC_ZERO,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	// Divider operand pairs.
	typedef enum logic {
		DIV_INTEG,
		DIV_SAT
	} div_sel_t;

	// Controller states.
	typedef enum logic [4:0] {
		S_IDLE,
		S_RATE,
		S_ERR,
		S_DIVI,
		S_WDIVI,
		S_M_EC,
		S_W_EC,
		S_M_IC,
		S_W_IC,
		S_SURF,
		S_M_TH,
		S_W_TH,
		S_SATC,
		S_WDIVS,
		S_M_EVC,
		S_W_EVC,
		S_M_EC2,
		S_W_EC2,
		S_M_SK,
		S_W_SK,
		S_M_SSE,
		S_W_SSE,
		S_M_UJ,
		S_W_UJ,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic rate_en;
		logic err_en;
		logic mul_start;
		mul_sel_t mul_sel;
		acc_op_t acc_op;
		logic surf_en;
		logic th_en;
		logic sat_en;
		logic div_start;
		div_sel_t div_sel;
		logic integ_en;
		logic ss_div_en;
		logic out_en;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mode;
		logic dead;
		logic mul_done;
		logic div_done;
		logic need_div;
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/smpc_mulq.sv =====
module smpc_mulq (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [47:0] a,
	input  logic [smpc_pkg::GAIN_W-1:0] g,
	output logic done,
	output logic signed [47:0] res
);
	import smpc_pkg::*;

	localparam logic [63:0] MAX48 = 64'h0000_7FFF_FFFF_FFFF;

	logic [1:0] ph_q;
	logic done_q;
	logic neg_q;
	logic [47:0] m_q;
	logic [GAIN_W-1:0] g_q;
	logic [54:0] hi_q;
	logic [54:0] lo_q;
	logic signed [47:0] res_q;
	logic [23:0] mop;
	logic [54:0] prod;
	logic [63:0] sum;
	logic [47:0] r48;

	// One 24 x 31 multiplier, used for the upper and then the lower half.
	assign mop = (ph_q == 2'd1) ? m_q[47:24] : m_q[23:0];
	assign prod = 55'(mop) * 55'(g_q);
	assign sum = {1'b0, hi_q, 8'b0} + 64'(lo_q[54:16]);
	assign r48 = (sum > MAX48) ? MAX48[47:0] : sum[47:0];

	// Phase counter and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				ph_q <= 2'd1;
			end else if (ph_q == 2'd3) begin
				ph_q <= 2'd0;
				done_q <= 1'b1;
			end else if (ph_q != 2'd0) begin
				ph_q <= ph_q + 2'd1;
			end
		end
	end

	// Magnitude, partial products and the signed, saturated result.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= a[47];
			m_q <= a[47] ? 48'(-a) : 48'(a);
			g_q <= g;
		end
		if (ph_q == 2'd1) begin
			hi_q <= prod;
		end
		if (ph_q == 2'd2) begin
			lo_q <= prod;
		end
		if (ph_q == 2'd3) begin
			res_q <= neg_q ? -$signed(r48) : $signed(r48);
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// ===== hdl/smpc_div.sv =====
module smpc_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [47:0] dividend,
	input  logic [smpc_pkg::GAIN_W-1:0] divisor,
	output logic done,
	output logic [47:0] quot
);
	import smpc_pkg::*;

	localparam int DVD_W = 48;

	logic busy_q;
	logic done_q;
	logic [5:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [GAIN_W-1:0] rem_q;
	logic [GAIN_W-1:0] dsr_q;
	logic [GAIN_W:0] trial;
	logic take;

	// One restoring step a cycle.
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign take = trial >= {1'b0, dsr_q};

	// Iteration counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? GAIN_W'(trial - {1'b0, dsr_q}) : GAIN_W'(trial);
			quo_q <= {quo_q[DVD_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// Division of a 48-bit magnitude by a fixed divisor through multiplication by a
// scaled reciprocal. The 48 x 49 bit product is built from four 24 x 25 bit
// partial products, one a cycle.
module smpc_cdiv #(
	parameter int DIVISOR = smpc_pkg::SAMPLE_RATE_HZ_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [47:0] dividend,
	output logic done,
	output logic [47:0] quot
);

	// The rounded-up reciprocal makes the truncated product exact for every
	// dividend below 2^48.
	localparam int SHIFT = 48 + $clog2(DIVISOR);
	localparam logic [65:0] SCALE = 66'd1 << SHIFT;
	localparam logic [65:0] RECIP_X = (SCALE + 66'(DIVISOR) - 66'd1) / 66'(DIVISOR);
	localparam logic [48:0] RECIP = RECIP_X[48:0];

	logic [2:0] ph_q;
	logic done_q;
	logic [47:0] n_q;
	logic [97:0] acc_q;
	logic [23:0] nop;
	logic [24:0] rop;
	logic [48:0] prod;

	// Upper and lower halves of the dividend and of the reciprocal.
	assign nop = (ph_q == 3'd1 || ph_q == 3'd2) ? n_q[47:24] : n_q[23:0];
	assign rop = (ph_q == 3'd1 || ph_q == 3'd3) ? RECIP[48:24] : {1'b0, RECIP[23:0]};
	assign prod = 49'(nop) * 49'(rop);

	// Phase counter and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				ph_q <= 3'd1;
			end else if (ph_q == 3'd4) begin
				ph_q <= 3'd0;
				done_q <= 1'b1;
			end else if (ph_q != 3'd0) begin
				ph_q <= ph_q + 3'd1;
			end
		end
	end

	// Horner accumulation of the four partial products.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
		end
		if (ph_q == 3'd1) begin
			acc_q <= 98'(prod);
		end
		if (ph_q == 3'd2 || ph_q == 3'd4) begin
			acc_q <= {acc_q[73:0], 24'b0} + 98'(prod);
		end
		if (ph_q == 3'd3) begin
			acc_q <= acc_q + 98'(prod);
		end
	end

	assign done = done_q;
	assign quot = 48'(acc_q >> SHIFT);

endmodule

// ===== hdl/smpc_datapath.sv =====
module smpc_datapath #(
	parameter int SAMPLE_RATE_HZ = smpc_pkg::SAMPLE_RATE_HZ_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  smpc_pkg::in_t in_data,
	output smpc_pkg::out_t out_data,
	output logic out_valid,
	input  logic out_stall,
	input  logic cfg_we,
	input  logic [smpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [smpc_pkg::GAIN_W-1:0] cfg_data,
	input  smpc_pkg::cmd_t cmd,
	output smpc_pkg::sts_t sts
);
	import smpc_pkg::*;

	localparam logic [SR_W-1:0] SR_V = SR_W'(SAMPLE_RATE_HZ);
	localparam logic signed [50:0] MAX32_X = 51'sd2147483647;
	localparam logic signed [50:0] MIN32_X = -51'sd2147483648;
	localparam logic signed [50:0] MAX48_X = 51'sd140737488355327;
	localparam logic signed [50:0] MIN48_X = -51'sd140737488355328;
	localparam logic signed [47:0] ONE_Q = 48'sd65536;

	function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
		if (v > MAX32_X) return MAX32_X[31:0];
		if (v < MIN32_X) return MIN32_X[31:0];
		return v[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
		if (v > MAX48_X) return MAX48_X[47:0];
		if (v < MIN48_X) return MIN48_X[47:0];
		return v[47:0];
	endfunction

	// Configuration registers.
	logic mode_q;
	logic [GAIN_W-1:0] gj_q, gk_q, gc_q, gc2_q, eps_q, lim_q, dmax_q;

	// Tick state and working registers.
	logic signed [31:0] tgt_q, pos_q, vel_q, prev_tgt_q;
	logic [30:0] dbw_q;
	logic signed [31:0] rate_q, e_q, ev_q, s_q;
	logic signed [47:0] isum_q, integ_q, th_q, ss_q;
	logic signed [50:0] acc_q;
	logic dead_q;
	logic out_valid_q;
	out_t out_q;

	logic signed [32:0] dtgt;
	logic signed [50:0] rate_prod;
	logic [31:0] abs_e;
	logic [31:0] abs_s;
	logic dead_c;
	logic signed [47:0] s48;
	logic ge_th, le_th;
	logic signed [47:0] mul_a;
	logic [GAIN_W-1:0] mul_g;
	logic mul_done;
	logic signed [47:0] mres;
	logic [47:0] div_dvd;
	logic [GAIN_W-1:0] div_dsr;
	logic div_go;
	logic div_done;
	logic [47:0] quot;
	logic [47:0] isum_mag;
	logic cdiv_go;
	logic cdiv_done;
	logic [47:0] cquot;
	logic signed [47:0] dmax48;
	logic out_free;

	// Target rate, error and deadband test.
	assign dtgt = 33'(tgt_q) - 33'(prev_tgt_q);
	assign rate_prod = dtgt * $signed({1'b0, SR_V});
	assign abs_e = e_q[31] ? 32'(-e_q) : 32'(e_q);
	assign abs_s = s_q[31] ? 32'(-s_q) : 32'(s_q);
	assign dead_c = abs_e < {1'b0, dbw_q};

	// Boundary layer test.
	assign s48 = 48'(s_q);
	assign ge_th = s48 >= th_q;
	assign le_th = s48 <= -th_q;

	// Multiplier operand selection.
	always_comb begin
		unique case (cmd.mul_sel)
			MS_EC: begin
				mul_a = 48'(e_q);
				mul_g = gc_q;
			end
			MS_IC: begin
				mul_a = integ_q;
				mul_g = gc2_q;
			end
			MS_TH: begin
				mul_a = $signed(48'(lim_q));
				mul_g = eps_q;
			end
			MS_EVC: begin
				mul_a = 48'(ev_q);
				mul_g = gc_q;
			end
			MS_EC2: begin
				mul_a = 48'(e_q);
				mul_g = gc2_q;
			end
			MS_SK: begin
				mul_a = 48'(s_q);
				mul_g = gk_q;
			end
			MS_SSE: begin
				mul_a = ss_q;
				mul_g = eps_q;
			end
			MS_UJ: begin
				mul_a = sat48(acc_q);
				mul_g = gj_q;
			end
			default: begin
				mul_a = '0;
				mul_g = '0;
			end
		endcase
	end

	// The integral goes to the reciprocal divider, the surface to the divider by epsilon.
	assign div_dvd = {abs_s, 16'b0};
	assign div_dsr = eps_q;
	assign div_go = cmd.div_start && (cmd.div_sel == DIV_SAT);
	assign cdiv_go = cmd.div_start && (cmd.div_sel == DIV_INTEG);
	assign isum_mag = isum_q[47] ? 48'(-isum_q) : 48'(isum_q);

	smpc_mulq u_mulq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.g      (mul_g),
		.done   (mul_done),
		.res    (mres)
	);

	smpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quot     (quot)
	);

	smpc_cdiv #(
		.DIVISOR (SAMPLE_RATE_HZ)
	) u_cdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cdiv_go),
		.dividend (isum_mag),
		.done     (cdiv_done),
		.quot     (cquot)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			gj_q <= '0;
			gk_q <= '0;
			gc_q <= '0;
			gc2_q <= '0;
			eps_q <= '0;
			lim_q <= '0;
			dmax_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MODE: mode_q <= cfg_data[0];
				REG_GAIN_J: gj_q <= cfg_data;
				REG_GAIN_K: gk_q <= cfg_data;
				REG_SURF_GAIN: gc_q <= cfg_data;
				REG_INT_GAIN: gc2_q <= cfg_data;
				REG_EPS: eps_q <= cfg_data;
				REG_SAT_LIMIT: lim_q <= cfg_data;
				REG_DRIVE_MAX: dmax_q <= cfg_data;
				default: mode_q <= mode_q;
			endcase
		end
	end

	// State carried from tick to tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_tgt_q <= '0;
			isum_q <= '0;
			s_q <= '0;
		end else begin
			if (cmd.rate_en) begin
				prev_tgt_q <= tgt_q;
			end
			if (cmd.err_en) begin
				isum_q <= sat48(51'(isum_q) + 51'(e_q));
			end
			if (cmd.surf_en) begin
				s_q <= sat32(acc_q);
			end
		end
	end

	// Working registers of one tick.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_q <= in_data.target_pos;
			pos_q <= in_data.measured_pos;
			vel_q <= in_data.measured_vel;
			dbw_q <= in_data.deadband_width;
		end
		if (cmd.rate_en) begin
			rate_q <= sat32(rate_prod);
			e_q <= sat32(51'(pos_q) - 51'(tgt_q));
		end
		if (cmd.err_en) begin
			ev_q <= sat32(51'(vel_q) - 51'(rate_q));
			dead_q <= dead_c;
		end
		if (cmd.integ_en) begin
			integ_q <= isum_q[47] ? -$signed(cquot) : $signed(cquot);
		end
		unique case (cmd.acc_op)
			ACC_HOLD: acc_q <= acc_q;
			ACC_EV: acc_q <= 51'(ev_q);
			ACC_ZERO: acc_q <= '0;
			ACC_ADD: acc_q <= acc_q + 51'(mres);
			ACC_SUB: acc_q <= acc_q - 51'(mres);
			default: acc_q <= acc_q;
		endcase
		if (cmd.th_en) begin
			th_q <= mres;
		end
		if (cmd.sat_en) begin
			priority if (ge_th) begin
				ss_q <= ONE_Q;
			end else if (le_th) begin
				ss_q <= -ONE_Q;
			end else if (eps_q == '0) begin
				ss_q <= s_q[31] ? -ONE_Q : ONE_Q;
			end else begin
				ss_q <= ss_q;
			end
		end
		if (cmd.ss_div_en) begin
			ss_q <= s_q[31] ? -$signed(quot) : $signed(quot);
		end
	end

	// Drive clamp and the result register.
	assign dmax48 = $signed(48'(dmax_q));
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_en) begin
			out_q.surface <= s_q;
			out_q.in_deadband <= dead_q;
			if (dead_q) begin
				out_q.drive <= '0;
				out_q.clamped <= 1'b0;
			end else if (mres > dmax48) begin
				out_q.drive <= dmax48[31:0];
				out_q.clamped <= 1'b1;
			end else if (mres < -dmax48) begin
				out_q.drive <= 32'(-dmax48);
				out_q.clamped <= 1'b1;
			end else begin
				out_q.drive <= mres[31:0];
				out_q.clamped <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign sts.mode = mode_q;
	assign sts.dead = dead_c;
	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done || cdiv_done;
	assign sts.need_div = !ge_th && !le_th && (eps_q != '0);
	assign sts.out_free = out_free;

endmodule

// ===== hdl/smpc_ctrl.sv =====
module smpc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  smpc_pkg::sts_t sts,
	output smpc_pkg::cmd_t cmd
);
	import smpc_pkg::*;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence of one tick: rate, errors, surface, switching term, drive; inside the deadband straight to the output.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.mul_sel = MS_EC;
		cmd.acc_op = ACC_HOLD;
		cmd.div_sel = DIV_INTEG;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_RATE;
				end
			end
			S_RATE: begin
				cmd.rate_en = 1'b1;
				state_d = S_ERR;
			end
			S_ERR: begin
				cmd.err_en = 1'b1;
				if (sts.dead) state_d = S_OUT;
				else if (sts.mode) state_d = S_DIVI;
				else state_d = S_M_EC;
			end
			S_DIVI: begin
				cmd.div_start = 1'b1;
				state_d = S_WDIVI;
			end
			S_WDIVI: begin
				if (sts.div_done) begin
					cmd.integ_en = 1'b1;
					state_d = S_M_EC;
				end
			end
			S_M_EC: begin
				cmd.mul_start = 1'b1;
				cmd.acc_op = ACC_EV;
				state_d = S_W_EC;
			end
			S_W_EC: begin
				if (sts.mul_done) begin
					cmd.acc_op = ACC_ADD;
					state_d = sts.mode ? S_M_IC : S_SURF;
				end
			end
			S_M_IC: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel = MS_IC;
				state_d = S_W_IC;
			end
			S_W_IC: begin
				if (sts.mul_done) begin
					cmd.acc_op = ACC_ADD;
					state_d = S_SURF;
				end
			end
			S_SURF: begin
				cmd.surf_en = 1'b1;
				cmd.acc_op = ACC_ZERO;
				state_d = S_M_TH;
			end
			S_M_TH: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel = MS_TH;
				state_d = S_W_TH;
			end
			S_W_TH: begin
				if (sts.mul_done) begin
					cmd.th_en = 1'b1;
					state_d = S_SATC;
				end
			end
			S_SATC: begin
				cmd.sat_en = 1'b1;
				if (sts.need_div) begin
					cmd.div_start = 1'b1;
					cmd.div_sel = DIV_SAT;
					state_d = S_WDIVS;
				end else begin
					state_d = S_M_EVC;
				end
			end
			S_WDIVS: begin
				if (sts.div_done) begin
					cmd.ss_div_en = 1'b1;
					state_d = S_M_EVC;
				end
			end
			S_M_EVC: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel = MS_EVC;
				state_d = S_W_EVC;
			end
			S_W_EVC: begin
				if (sts.mul_done) begin
					cmd.acc_op = ACC_SUB;
					state_d = sts.mode ? S_M_EC2 : S_M_SK;
				end
			end
			S_M_EC2: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel = MS_EC2;
				state_d = S_W_EC2;
			end
			S_W_EC2: begin
				if (sts.mul_done) begin
					cmd.acc_op = ACC_SUB;
					state_d = S_M_SK;
				end
			end
			S_M_SK: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel = MS_SK;
				state_d = S_W_SK;
			end
			S_W_SK: begin
				if (sts.mul_done) begin
					cmd.acc_op = ACC_SUB;
					state_d = S_M_SSE;
				end
			end
			S_M_SSE: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel = MS_SSE;
				state_d = S_W_SSE;
			end
			S_W_SSE: begin
				if (sts.mul_done) begin
					cmd.acc_op = ACC_SUB;
					state_d = S_M_UJ;
				end
			end
			S_M_UJ: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel = MS_UJ;
				state_d = S_W_UJ;
			end
			S_W_UJ: begin
				if (sts.mul_done) state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_en = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	// The multiplier and the divider are never started together.
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !cmd.div_start)
		else $error("multiplier and divider started together");

	// A result is never written over one that waits for transfer.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_en |-> sts.out_free)
		else $error("result register overwritten");

	// An accepted item always begins with the rate step.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_RATE)
		else $error("tick did not start with the rate step");

endmodule

// ===== hdl/sliding_mode_position_controller.sv =====
// Sliding mode position controller. Each accepted input item is one control
// tick: the target rate, the position and velocity errors and a saturating
// 48-bit error sum are formed, then either the deadband result or the sliding
// surface and the clamped drive are produced as one result item. Positions,
// velocities, the surface and the drive are Q16.16. Integral mode adds to
// exponential mode two more products and the division of the error sum by the
// sample rate, and a surface inside the boundary layer adds the division by
// epsilon. The arithmetic uses one shared 24 x 31 bit multiplier for the gain
// products, a reciprocal multiplication in four steps for the division by the
// sample rate, and one radix-2 divider that takes 48 iterations for the
// division by epsilon. The next item is taken as soon as the result has gone
// to the output register, even while that result still waits for transfer.
module sliding_mode_position_controller #(
	parameter int SAMPLE_RATE_HZ = smpc_pkg::SAMPLE_RATE_HZ_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  smpc_pkg::in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output smpc_pkg::out_t out_data,
	input  logic cfg_we,
	input  logic [smpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [smpc_pkg::GAIN_W-1:0] cfg_data
);
	import smpc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	smpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Arithmetic, state and result register.
	smpc_datapath #(
		.SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== test/tb_sliding_mode_position_controller.sv =====
`timescale 1ns / 1ps

module tb_sliding_mode_position_controller;
	import smpc_pkg::*;

	localparam int RATE_HZ = 1000;
	localparam longint MAX48 = 64'sh7FFF_FFFF_FFFF;
	localparam longint MIN48 = -MAX48 - 1;
	localparam longint ONE_Q16 = 65536;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [GAIN_W-1:0] cfg_data;

	// Predictor copy of the registers and the tick state.
	logic pm_mode;
	logic [30:0] pm_j, pm_k, pm_c, pm_c2, pm_eps, pm_lim, pm_dmax;
	longint pm_prev_target, pm_integral, pm_held_surface;

	out_t expected_q[$];
	int errors;
	int n_checked;
	int n_dead;
	int n_clamped;
	bit tail_quiet;
	bit hold_receiver;

	sliding_mode_position_controller i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint clip48(longint v);
		return v > MAX48 ? MAX48 : (v < MIN48 ? MIN48 : v);
	endfunction

	function automatic longint clip32(longint v);
		return v > 64'sd2147483647 ? 64'sd2147483647 :
			(v < -64'sd2147483648 ? -64'sd2147483648 : v);
	endfunction

	// Value times an unsigned Q15.16 gain, truncated toward zero, saturated to 48 bits.
	function automatic longint gain_product(longint a, logic [30:0] g);
		longint unsigned m, r;
		logic [127:0] p;
		bit neg;
		a = clip48(a);
		neg = a < 0;
		m = neg ? longint'(-a) : longint'(a);
		p = {64'd0, m} * {97'd0, g};
		p = p >> 16;
		r = (p > 128'(MAX48)) ? longint'(MAX48) : p[63:0];
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint boundary_sat(longint s);
		longint th;
		th = gain_product(longint'(pm_lim), pm_eps);
		if (s >= th) return ONE_Q16;
		if (s <= -th) return -ONE_Q16;
		if (pm_eps == 0) return s >= 0 ? ONE_Q16 : -ONE_Q16;
		return clip48((s * ONE_Q16) / longint'(pm_eps));
	endfunction

	// Works out the result of one control tick and advances the predictor state.
	function automatic out_t predict_tick(in_t it);
		out_t r;
		longint tgt, rate, e, ev, s, ss, inner, u, dmax, integ;
		tgt = longint'(it.target_pos);
		rate = clip32((tgt - pm_prev_target) * RATE_HZ);
		e = clip32(longint'(it.measured_pos) - tgt);
		ev = clip32(longint'(it.measured_vel) - rate);
		pm_integral = clip48(pm_integral + e);
		pm_prev_target = tgt;
		r = '0;
		if ((e < 0 ? -e : e) < longint'(it.deadband_width)) begin
			r.surface = 32'(pm_held_surface);
			r.in_deadband = 1'b1;
			return r;
		end
		if (!pm_mode) begin
			s = clip32(gain_product(e, pm_c) + ev);
			ss = boundary_sat(s);
			inner = clip48(-gain_product(ev, pm_c) - gain_product(s, pm_k)
				- gain_product(ss, pm_eps));
		end else begin
			integ = pm_integral / RATE_HZ;
			s = clip32(gain_product(e, pm_c) + ev + gain_product(integ, pm_c2));
			ss = boundary_sat(s);
			inner = clip48(-gain_product(ev, pm_c) - gain_product(e, pm_c2)
				- gain_product(s, pm_k) - gain_product(ss, pm_eps));
		end
		pm_held_surface = s;
		u = gain_product(inner, pm_j);
		dmax = longint'(pm_dmax);
		if (u > dmax) begin
			u = dmax;
			r.clamped = 1'b1;
		end else if (u < -dmax) begin
			u = -dmax;
			r.clamped = 1'b1;
		end
		r.drive = 32'(u);
		r.surface = 32'(s);
		return r;
	endfunction

	// Writes one register; only called while the block is idle.
	task automatic write_reg(reg_idx_t idx, logic [30:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MODE: pm_mode = val[0];
			REG_GAIN_J: pm_j = val;
			REG_GAIN_K: pm_k = val;
			REG_SURF_GAIN: pm_c = val;
			REG_INT_GAIN: pm_c2 = val;
			REG_EPS: pm_eps = val;
			REG_SAT_LIMIT: pm_lim = val;
			default: pm_dmax = val;
		endcase
	endtask

	task automatic write_all(logic md, logic [30:0] j, logic [30:0] k, logic [30:0] c,
			logic [30:0] c2, logic [30:0] eps, logic [30:0] lim, logic [30:0] dm);
		write_reg(REG_MODE, {30'd0, md});
		write_reg(REG_GAIN_J, j);
		write_reg(REG_GAIN_K, k);
		write_reg(REG_SURF_GAIN, c);
		write_reg(REG_INT_GAIN, c2);
		write_reg(REG_EPS, eps);
		write_reg(REG_SAT_LIMIT, lim);
		write_reg(REG_DRIVE_MAX, dm);
	endtask

	// Stops offering ticks, waits for every expected result, then for the block to settle.
	task automatic drain();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (expected_q.size() != 0 && guard < 2000000) begin
			@(posedge clk);
			guard++;
		end
		repeat (300) @(posedge clk);
	endtask

	// Sends one tick, with an optional random gap first. Valid stays high after
	// the transfer so that ticks can follow back to back.
	task automatic send_tick(in_t it, bit allow_gap);
		if (allow_gap && !tail_quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_q.push_back(predict_tick(it));
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
			3: return 32'(signed'($urandom_range(0, 1 << 24)) - (1 << 23));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] rand_gain();
		case ($urandom_range(0, 6))
			0: return 31'd0;
			1: return 31'h7FFF_FFFF;
			2: return 31'($urandom_range(0, 1 << 18));
			3: return 31'd65536;
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic in_t rand_tick(logic [31:0] prev);
		in_t it;
		it.target_pos = ($urandom_range(0, 2) == 0) ? rand_word()
			: prev + 32'(signed'($urandom_range(0, 4000)) - 2000);
		it.measured_pos = ($urandom_range(0, 2) == 0) ? rand_word()
			: it.target_pos + 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
		it.measured_vel = rand_word();
		case ($urandom_range(0, 3))
			0: it.deadband_width = 31'd0;
			1: it.deadband_width = 31'($urandom_range(0, 1 << 19));
			2: it.deadband_width = 31'h7FFF_FFFF;
			default: it.deadband_width = 31'($urandom);
		endcase
		return it;
	endfunction

	task automatic test_directed();
		in_t it;
		write_all(1'b0, 31'd65536, 31'd65536, 31'd65536, 31'd0, 31'd65536, 31'd65536,
			31'h7FFF_FFFF);
		it = '{32'sd0, 32'sd0, 32'sd0, 31'd0};
		send_tick(it, 0);
		it = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'd0};
		send_tick(it, 0);
		it = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'd0};
		send_tick(it, 0);
		it = '{32'sd100, 32'sd150, 32'sd0, 31'h7FFF_FFFF};
		send_tick(it, 0);
		it = '{32'sd100, 32'sd100, 32'sd0, 31'd0};
		send_tick(it, 0);
		it = '{32'sd100, 32'sd120, 32'sd10, 31'd20};
		send_tick(it, 0);
		it = '{32'sd100, 32'sd120, 32'sd10, 31'd21};
		send_tick(it, 0);
		drain();
		// Zero epsilon: the switching term takes the sign of the surface.
		write_all(1'b0, 31'd65536, 31'd0, 31'd65536, 31'd0, 31'd0, 31'd0, 31'd0);
		it = '{32'sd100, 32'sd100, 32'sd0, 31'd0};
		send_tick(it, 0);
		it = '{32'sd100, 32'sd99, 32'sd0, 31'd0};
		send_tick(it, 0);
		drain();
		// Integral mode with all gains at the top and a tight clamp.
		write_all(1'b1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1000);
		for (int i = 0; i < 6; i++) begin
			it = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, 31'd0};
			send_tick(it, 0);
		end
		it = '{32'sd0, 32'sd3, 32'sd1, 31'd0};
		send_tick(it, 0);
		drain();
		// Inside the boundary layer: surface divided by a large epsilon.
		write_all(1'b1, 31'd65536, 31'd100, 31'd65536, 31'd6553, 31'h4000_0000,
			31'd65536, 31'h7FFF_FFFF);
		it = '{32'sd0, 32'sd5000, 32'sd0, 31'd0};
		send_tick(it, 0);
		it = '{32'sd0, -32'sd5000, -32'sd7, 31'd0};
		send_tick(it, 0);
		drain();
	endtask

	task automatic test_random(int n_ticks, int phases);
		in_t it;
		logic [31:0] prev;
		prev = '0;
		for (int p = 0; p < phases; p++) begin
			write_all(1'($urandom_range(0, 1)), rand_gain(), rand_gain(), rand_gain(),
				rand_gain(), rand_gain(), rand_gain(), rand_gain());
			for (int i = 0; i < n_ticks; i++) begin
				it = rand_tick(prev);
				prev = it.target_pos;
				send_tick(it, 1);
			end
			drain();
		end
	endtask

	// The receiver holds off for a long stretch while ticks keep coming.
	task automatic test_backpressure();
		in_t it;
		write_all(1'b0, 31'd65536, 31'd32768, 31'd65536, 31'd0, 31'd65536, 31'd2,
			31'h0100_0000);
		hold_receiver = 1'b1;
		fork
			begin
				for (int i = 0; i < 40; i++) begin
					it = rand_tick(32'd0);
					send_tick(it, 0);
				end
			end
			begin
				repeat (600) @(posedge clk);
				hold_receiver = 1'b0;
			end
		join
		drain();
	endtask

	// Receiver side: random stall bursts, quiet at the tail.
	initial begin
		int burst;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_receiver) begin
				out_stall <= 1'b1;
			end else if (!tail_quiet && burst == 0 && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 15);
				out_stall <= 1'b1;
			end else if (burst > 0) begin
				burst--;
				if (burst == 0) out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Compares each transfer on the result side with the oldest expectation.
	always @(posedge clk) begin
		out_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				n_checked++;
				if (exp_r.in_deadband) n_dead++;
				if (exp_r.clamped) n_clamped++;
				if (out_data.drive !== exp_r.drive) begin
					$display("%0t: drive expected %0d actual %0d", $time, exp_r.drive,
						out_data.drive);
					errors++;
				end
				if (out_data.surface !== exp_r.surface) begin
					$display("%0t: surface expected %0d actual %0d", $time,
						exp_r.surface, out_data.surface);
					errors++;
				end
				if (out_data.in_deadband !== exp_r.in_deadband) begin
					$display("%0t: in_deadband expected %0b actual %0b", $time,
						exp_r.in_deadband, out_data.in_deadband);
					errors++;
				end
				if (out_data.clamped !== exp_r.clamped) begin
					$display("%0t: clamped expected %0b actual %0b", $time,
						exp_r.clamped, out_data.clamped);
					errors++;
				end
			end
		end
	end

	initial begin
		#200ms;
		$display("FAIL");
		$finish;
	end

	initial begin
		errors = 0;
		n_checked = 0;
		n_dead = 0;
		n_clamped = 0;
		tail_quiet = 1'b0;
		hold_receiver = 1'b0;
		pm_mode = 1'b0;
		{pm_j, pm_k, pm_c, pm_c2, pm_eps, pm_lim, pm_dmax} = '0;
		pm_prev_target = 0;
		pm_integral = 0;
		pm_held_surface = 0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random(150, 8);
		tail_quiet = 1'b1;
		test_random(100, 3);
		drain();

		$display("Checked %0d ticks: %0d in the deadband, %0d with the drive clamped.",
			n_checked, n_dead, n_clamped);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
